/* rtl/core/aids_pkg.sv */
// Package for the packed-list block: transfer structs, command and status codes,
// cell control and state machine types. Depends on nothing.
`default_nettype none

package aids_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int ROT_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_SEARCH  = 3'd2;
    localparam logic [2:0] CMD_ROTATE  = 3'd3;
    localparam logic [2:0] CMD_DISPLAY = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]                command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] key;
        logic [ROT_W-1:0]          rotations;
    } t_item;

    typedef struct packed {
        logic [2:0]                status;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] element;
        logic                      last;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTL
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode                mode;
        logic [POS_W-1:0]          position;
        logic [CNT_W-1:0]          count;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_ROT,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/aids_cell.sv */
// One storage cell of the list chain: holds one element and takes its
// neighbour's value on insert, delete and left rotation. Uses aids_pkg.
`default_nettype none

module aids_cell
    import aids_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire                        i_clk,
    input  t_cell_ctl                  i_ctl,
    input  wire signed [VALUE_W-1:0]   i_left,
    input  wire signed [VALUE_W-1:0]   i_right,
    input  wire signed [VALUE_W-1:0]   i_head,
    output logic signed [VALUE_W-1:0]  o_data
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.mode)
            CELL_INSERT: begin
                if (IDX == i_ctl.position) begin
                    n_data = i_ctl.value;
                end else if (IDX > i_ctl.position && IDX_NEXT <= i_ctl.count + 7'd1) begin
                    n_data = i_left;
                end
            end
            CELL_DELETE: begin
                if (IDX >= i_ctl.position && IDX_NEXT < i_ctl.count) begin
                    n_data = i_right;
                end
            end
            CELL_ROTL: begin
                if (IDX_NEXT < i_ctl.count) begin
                    n_data = i_right;
                end else if (IDX_NEXT == i_ctl.count) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // payload only: hold until a command moves it
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/core/aids_mod.sv */
// Restoring remainder unit: one dividend bit per cycle, reduces the rotation
// count modulo the element count. Uses aids_pkg.
`default_nettype none

module aids_mod
    import aids_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [ROT_W-1:0]     i_dividend,
    input  wire [CNT_W-1:0]     i_divisor,
    output logic                o_done,
    output logic [CNT_W-1:0]    o_rem
);

    localparam int STEP_W = $clog2(ROT_W + 1);

    logic               r_run;
    logic               n_run;
    logic [STEP_W-1:0]  r_left;
    logic [STEP_W-1:0]  n_left;
    logic               r_done;
    logic               n_done;
    logic [ROT_W-1:0]   r_dvd;
    logic [ROT_W-1:0]   n_dvd;
    logic [CNT_W-1:0]   r_div;
    logic [CNT_W-1:0]   n_div;
    logic [CNT_W:0]     r_rem;
    logic [CNT_W:0]     n_rem;
    logic [CNT_W:0]     w_trial;

    always_comb begin
        n_run   = r_run;
        n_left  = r_left;
        n_done  = 1'b0;
        n_dvd   = r_dvd;
        n_div   = r_div;
        n_rem   = r_rem;
        w_trial = {r_rem[CNT_W-1:0], r_dvd[ROT_W-1]};
        if (i_start) begin
            n_run  = 1'b1;
            n_left = STEP_W'(ROT_W);
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_run) begin
            // shift in the next bit, subtract when it fits
            n_dvd  = {r_dvd[ROT_W-2:0], 1'b0};
            n_rem  = (w_trial >= {1'b0, r_div}) ? w_trial - {1'b0, r_div} : w_trial;
            n_left = r_left - 1'b1;
            if (r_left == STEP_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_left <= n_left;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CNT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/array_insert_delete_search_rotate.sv */
// Packed list of signed 32-bit elements held in a chain of cells, with count.
// Insert, delete and commands on an empty list give their one result in the
// cycle after transfer and leave busy low. Search scans the list once, display
// emits one result per cycle, and rotate runs the remainder unit and then up to
// count-1 left rotation steps.
// Reset (synchronous, active low) clears count and control; cell contents
// stay undefined until written. Results cannot be stalled by the receiver.
`default_nettype none

module array_insert_delete_search_rotate
    import aids_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  t_item    i_item,
    output logic     busy,
    output logic     o_valid,
    output t_result  o_res
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_step;
    logic [CNT_W-1:0]  n_step;
    logic              r_found;
    logic              n_found;
    logic [IDX_W-1:0]  r_fidx;
    logic [IDX_W-1:0]  n_fidx;
    logic              r_disp;
    logic              n_disp;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] n_key;
    logic              r_valid;
    logic              n_valid;
    t_result           r_res;
    t_result           n_res;

    t_cell_ctl         w_ctl;
    logic              w_accept;
    logic              w_mod_start;
    logic              w_mod_done;
    logic [CNT_W-1:0]  w_mod_rem;
    logic              w_match;
    logic [POS_W-1:0]  w_cnt_pos;
    logic signed [VALUE_W-1:0] w_data [CAPACITY];

    assign w_accept  = start && !busy;
    assign w_cnt_pos = POS_W'(r_count);
    assign w_match   = (w_data[0] == r_key);

    // Remainder unit for rotate: rotations mod count
    aids_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_item.rotations),
        .i_divisor  (r_count),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Chain of cells; cell 0 is the head, seen by every cell for the wrap
    // of a left rotation
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        aids_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_step  <= n_step;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_disp  <= n_disp;
        r_key   <= n_key;
        r_res   <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_disp       = r_disp;
        n_key        = r_key;
        n_valid      = 1'b0;
        n_res        = r_res;
        w_mod_start  = 1'b0;
        w_ctl.mode     = CELL_HOLD;
        w_ctl.position = i_item.position;
        w_ctl.count    = r_count;
        w_ctl.value    = i_item.value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // single-result default: status filled in below
                    n_res.status  = ST_OK;
                    n_res.index   = '0;
                    n_res.element = '0;
                    n_res.last    = 1'b1;
                    unique case (i_item.command)
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (r_count >= CAP) begin
                                n_res.status = ST_FULL;
                            end else if (i_item.position > w_cnt_pos) begin
                                n_res.status = ST_BADPOS;
                            end else begin
                                w_ctl.mode = CELL_INSERT;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            n_valid = 1'b1;
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (i_item.position >= w_cnt_pos) begin
                                n_res.status = ST_BADPOS;
                            end else begin
                                w_ctl.mode = CELL_DELETE;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                                n_disp  = 1'b0;
                                n_key   = i_item.key;
                                n_step  = '0;
                                n_found = 1'b0;
                                n_fidx  = '0;
                            end
                        end
                        CMD_ROTATE: begin
                            if (r_count == '0) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                w_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (r_count == '0) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                                n_disp  = 1'b1;
                                n_step  = '0;
                            end
                        end
                        default: begin
                            // unused codes: drop without a result
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_MOD: begin
                // right by r equals left by count - r
                if (w_mod_done) begin
                    n_step  = (w_mod_rem == '0) ? '0 : r_count - w_mod_rem;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_step == '0) begin
                    n_valid       = 1'b1;
                    n_res.status  = ST_OK;
                    n_res.index   = '0;
                    n_res.element = '0;
                    n_res.last    = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    w_ctl.mode = CELL_ROTL;
                    n_step     = r_step - 1'b1;
                end
            end
            S_SCAN: begin
                // read the head, rotate left; after count steps the list is back
                w_ctl.mode = CELL_ROTL;
                n_step     = r_step + 1'b1;
                if (r_disp) begin
                    n_valid       = 1'b1;
                    n_res.status  = ST_OK;
                    n_res.index   = r_step[IDX_W-1:0];
                    n_res.element = w_data[0];
                    n_res.last    = (r_step + 1'b1 == r_count);
                end else if (!r_found && w_match) begin
                    n_found = 1'b1;
                    n_fidx  = r_step[IDX_W-1:0];
                end
                if (r_step + 1'b1 == r_count) begin
                    n_state = S_IDLE;
                    if (!r_disp) begin
                        n_valid       = 1'b1;
                        n_res.element = '0;
                        n_res.last    = 1'b1;
                        if (r_found) begin
                            n_res.status = ST_OK;
                            n_res.index  = r_fidx;
                        end else if (w_match) begin
                            n_res.status = ST_OK;
                            n_res.index  = r_step[IDX_W-1:0];
                        end else begin
                            n_res.status = ST_NOTFOUND;
                            n_res.index  = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // The count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("element count above capacity");

    // The final result of an item leaves the block free for the next one
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last |-> !busy)
        else $error("final result while still busy");

    // Results that are not final only come from a display in progress
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last |-> busy)
        else $error("intermediate result while idle");

    // A successful insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_item.command == CMD_INSERT && r_count < CAP
            && i_item.position <= w_cnt_pos
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    // The remainder unit reports only while the block waits for it
    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == S_MOD)
        else $error("remainder ready outside rotate");

endmodule

`default_nettype wire

/* dv/array_insert_delete_search_rotate_test.sv */
// Self-checking bench for the packed-list block: directed and random commands,
// results predicted from a shadow list and compared field by field.
// Depends on aids_pkg and array_insert_delete_search_rotate.
`timescale 1ns / 1ps

module array_insert_delete_search_rotate_test;
    import aids_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 156;
    localparam int CALM_TAIL      = 25;        // pending commands sent without idling
    localparam int SETTLE_CYCLES  = 100;       // idle margin after the last result
    localparam int RUN_LIMIT_NS   = 4_000_000;
    localparam int MAX_PRINTED    = 40;

    // Command codes the block ignores.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_res;

    array_insert_delete_search_rotate #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_item (i_item),
        .busy   (busy),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Commands waiting for the driver, and results the list owes us.
    t_item   queued_commands[$];
    t_result results_due[$];

    // Shadow copy of the list, advanced at every accepted transfer.
    logic signed [VALUE_W-1:0] list_elems [LIST_DEPTH];
    int                        list_count = 0;

    // Element count as the stimulus generator sees it when it queues commands.
    int  planned_count = 0;

    bit  item_taken = 1'b0;
    int  gap_left = 0;
    int  fail_count = 0;
    int  results_checked = 0;
    int  full_reached = 0;
    int  commands_seen [5] = '{default: 0};
    logic signed [VALUE_W-1:0] value_pool [8];

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // Advance the shadow list by one command and queue what it must produce.
    task automatic predict_list_op(input t_item it);
        t_result                   res;
        logic signed [VALUE_W-1:0] rotated [LIST_DEPTH];
        int                        shift;
        bit                        hit;
        res      = '0;
        res.last = 1'b1;
        hit      = 1'b0;
        if (it.command <= CMD_DISPLAY)
            commands_seen[it.command]++;
        case (it.command)
            CMD_INSERT: begin
                // Full is checked ahead of the position.
                if (list_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (it.position > list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = list_count; i > it.position; i--)
                        list_elems[i] = list_elems[i-1];
                    list_elems[it.position] = it.value;
                    list_count++;
                    if (list_count == LIST_DEPTH)
                        full_reached++;
                    res.status = ST_OK;
                end
                results_due.push_back(res);
            end
            CMD_DELETE: begin
                // Empty is checked ahead of the position.
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (it.position >= list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = it.position; i + 1 < list_count; i++)
                        list_elems[i] = list_elems[i+1];
                    list_count--;
                    res.status = ST_OK;
                end
                results_due.push_back(res);
            end
            CMD_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < list_count; i++) begin
                    if (!hit && list_elems[i] == it.key) begin
                        hit        = 1'b1;
                        res.status = ST_OK;
                        res.index  = IDX_W'(i);
                    end
                end
                results_due.push_back(res);
            end
            CMD_ROTATE: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shift = it.rotations % list_count;
                    for (int i = 0; i < list_count; i++)
                        rotated[(i + shift) % list_count] = list_elems[i];
                    for (int i = 0; i < list_count; i++)
                        list_elems[i] = rotated[i];
                    res.status = ST_OK;
                end
                results_due.push_back(res);
            end
            CMD_DISPLAY: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                    results_due.push_back(res);
                end else begin
                    for (int i = 0; i < list_count; i++) begin
                        res.status  = ST_OK;
                        res.index   = IDX_W'(i);
                        res.element = list_elems[i];
                        res.last    = (i == list_count - 1);
                        results_due.push_back(res);
                    end
                end
            end
            default: ;  // spare codes: no result, no change
        endcase
    endtask

    // Random item, so that fields a command ignores still toggle.
    function automatic t_item rand_item();
        t_item it;
        it.command   = CMD_INSERT;
        it.position  = POS_W'($urandom_range(0, 127));
        it.value     = $urandom;
        it.key       = $urandom;
        it.rotations = ROT_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Queue one command and track the element count it leaves behind.
    task automatic push_command(input t_item it);
        case (it.command)
            CMD_INSERT:
                if (planned_count < LIST_DEPTH && it.position <= planned_count)
                    planned_count++;
            CMD_DELETE:
                if (planned_count > 0 && it.position < planned_count)
                    planned_count--;
            default: ;
        endcase
        queued_commands.push_back(it);
    endtask

    // Directed command: data lands in value for inserts and key for searches.
    task automatic issue(input logic [2:0] cmd, input int pos,
                         input logic signed [VALUE_W-1:0] data, input int rot);
        t_item it;
        it           = rand_item();
        it.command   = cmd;
        it.position  = POS_W'(pos);
        it.rotations = ROT_W'(rot);
        if (cmd == CMD_INSERT)
            it.value = data;
        if (cmd == CMD_SEARCH)
            it.key = data;
        push_command(it);
    endtask

    // Random command drawn around the current count; mostly well formed.
    task automatic issue_random(input bit growing);
        t_item it;
        int    r;
        int    ins_w;
        int    del_w;
        bit    sane;
        it    = rand_item();
        ins_w = growing ? 45 : 10;
        del_w = growing ? 15 : 50;
        sane  = ($urandom_range(0, 99) < 85);
        r     = $urandom_range(0, 99);
        if (r < ins_w) begin
            it.command = CMD_INSERT;
            it.value   = pick_value();
            if (sane)
                it.position = POS_W'($urandom_range(0, planned_count));
        end else if (r < ins_w + del_w) begin
            it.command = CMD_DELETE;
            if (sane && planned_count > 0)
                it.position = POS_W'($urandom_range(0, planned_count - 1));
        end else if (r < ins_w + del_w + 20) begin
            it.command = CMD_SEARCH;
            if ($urandom_range(0, 99) < 65)
                it.key = value_pool[$urandom_range(0, 7)];
        end else if (r < ins_w + del_w + 32) begin
            it.command = CMD_ROTATE;
            if ($urandom_range(0, 1) == 0)
                it.rotations = ROT_W'($urandom_range(0, 2 * planned_count + 1));
        end else if (r < ins_w + del_w + 37) begin
            it.command = CMD_DISPLAY;
        end else begin
            it.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        push_command(it);
    endtask

    // Check what the list produced and take note of accepted transfers.
    always @(posedge i_clk) begin
        t_result want;
        item_taken = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (results_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected result, status %0d", o_res.status));
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (o_res.status !== want.status)
                        note_mismatch($sformatf("status got %0d want %0d",
                                                o_res.status, want.status));
                    if (o_res.index !== want.index)
                        note_mismatch($sformatf("index got %0d want %0d",
                                                o_res.index, want.index));
                    if (o_res.element !== want.element)
                        note_mismatch($sformatf("element got %0d want %0d",
                                                o_res.element, want.element));
                    if (o_res.last !== want.last)
                        note_mismatch($sformatf("last got %0b want %0b",
                                                o_res.last, want.last));
                end
            end
            if (start && !busy) begin
                item_taken = 1'b1;
                predict_list_op(i_item);
            end
        end
    end

    // Drive at the falling edge. Hold an offered command until the block takes it;
    // after each transfer, sometimes drop start for a burst of idle cycles.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || item_taken)) begin
            if (item_taken && queued_commands.size() > CALM_TAIL
                    && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 12);
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (queued_commands.size() != 0) begin
                i_item <= queued_commands.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        int  random_items;
        bit  growing;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;

        value_pool[0] = 0;
        value_pool[1] = -1;
        value_pool[2] = 32'sh7FFF_FFFF;
        value_pool[3] = 32'sh8000_0000;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Empty list: each command reports empty, a miss or a bad position.
        issue(CMD_DISPLAY, 0, 0, 0);
        issue(CMD_DELETE, 0, 0, 0);
        issue(CMD_ROTATE, 0, 0, 5);
        issue(CMD_SEARCH, 0, 0, 0);
        issue(CMD_INSERT, 1, 0, 0);                 // past the end
        // Build [-1, max, min, 0] using both ends.
        issue(CMD_INSERT, 0, 32'sh7FFF_FFFF, 0);
        issue(CMD_INSERT, 1, 32'sh8000_0000, 0);
        issue(CMD_INSERT, 0, -1, 0);
        issue(CMD_INSERT, 127, 0, 0);               // widest bad position
        issue(CMD_INSERT, 3, 0, 0);
        issue(CMD_SEARCH, 0, 32'sh8000_0000, 0);
        issue(CMD_SEARCH, 0, 32'sh1234_5678, 0);    // miss
        issue(CMD_SEARCH, 0, -1, 0);                // hit at index zero
        issue(CMD_ROTATE, 0, 0, 16'hFFFF);
        issue(CMD_ROTATE, 0, 0, 0);
        issue(CMD_DISPLAY, 0, 0, 0);
        issue(CMD_DELETE, 4, 0, 0);                 // position equal to count
        issue(CMD_DELETE, 127, 0, 0);
        issue(CMD_DELETE, 3, 0, 0);                 // tail element
        issue(CMD_DELETE, 0, 0, 0);                 // head element
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            issue(3'(c), 0, 0, 0);
        issue(CMD_ROTATE, 0, 0, 1);
        issue(CMD_DISPLAY, 0, 0, 0);

        // Load to capacity, mostly appending, then poke the full list.
        random_items = 0;
        while (planned_count < LIST_DEPTH) begin
            if ($urandom_range(0, 3) == 0)
                issue(CMD_INSERT, $urandom_range(0, planned_count), pick_value(), 0);
            else
                issue(CMD_INSERT, planned_count, pick_value(), 0);
            random_items++;
        end
        issue(CMD_INSERT, 0, pick_value(), 0);
        issue(CMD_INSERT, 127, pick_value(), 0);
        issue(CMD_SEARCH, 0, value_pool[$urandom_range(0, 7)], 0);
        issue(CMD_ROTATE, 0, 0, $urandom_range(0, 65535));
        issue(CMD_DISPLAY, 0, 0, 0);
        issue(CMD_DELETE, LIST_DEPTH, 0, 0);
        issue(CMD_DELETE, LIST_DEPTH - 1, 0, 0);
        random_items += 7;

        // Drift between full and empty, turning round at either extreme.
        growing = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (planned_count == LIST_DEPTH)
                growing = 1'b0;
            else if (planned_count == 0)
                growing = 1'b1;
            issue_random(growing);
            if (queued_commands[$].command <= CMD_DISPLAY)
                random_items++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every result to arrive.
        while (queued_commands.size() != 0 || start || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Commands taken: %0d insert, %0d delete, %0d search, %0d rotate, %0d display",
                 commands_seen[CMD_INSERT], commands_seen[CMD_DELETE],
                 commands_seen[CMD_SEARCH], commands_seen[CMD_ROTATE],
                 commands_seen[CMD_DISPLAY]);
        $display("Results checked: %0d; list filled to capacity %0d times; %0d mismatches",
                 results_checked, full_reached, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Drop the run if the block stops answering.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results outstanding", results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
